[rtl/fuzzy_signal_extension_top_assert.svh]
// assertion macros for the fuzzy extension block
`ifndef FUZZY_SIGNAL_EXTENSION_TOP_ASSERT_SVH
`define FUZZY_SIGNAL_EXTENSION_TOP_ASSERT_SVH

// same-cycle implication
`define FSE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fse_pkg.sv]
package fse_pkg;

   localparam int CountWidth   = 8;
   localparam int ExtWidth     = 7;
   localparam int TableWidth   = 32;
   localparam int AddrWidth    = 3;
   localparam int NumSets      = 4;
   localparam int SetIdxWidth  = 2;
   localparam int ConsWidth    = 2;
   localparam int CentreStep   = 3;
   localparam int Tenths       = 10;
   localparam int ScaleNum     = 2 * Tenths * CentreStep;

   localparam int MuWidth      = 4;
   localparam int ProdWidth    = 5;
   localparam int RowSumWidth  = 7;
   localparam int RowDenWidth  = 6;
   localparam int SumWidth     = 9;
   localparam int DenWidth     = 8;
   localparam int NumWidth     = 15;
   localparam int DivWidth     = 9;
   localparam int QuoWidth     = 7;
   localparam int QuoIdxWidth  = 3;
   localparam int ExtMax       = 90;

   localparam logic [TableWidth-1:0] RuleTableReset = 32'h1B06_0100;
   localparam logic [AddrWidth-1:0]  RuleTableAddr  = 3'd0;

   localparam logic [MuWidth-1:0] MuFull = 4'd10;
   localparam logic [MuWidth-1:0] MuNear = 4'd7;
   localparam logic [MuWidth-1:0] MuFar  = 4'd3;
   localparam logic [MuWidth-1:0] MuNone = 4'd0;

   typedef struct packed {
      logic [NumWidth-1:0] rem;
      logic [DivWidth-1:0] div;
      logic [QuoWidth-1:0] quo;
      logic                none;
   } div_state_type;

endpackage

[rtl/fse_req_if.sv]
interface fse_req_if;
   logic                            valid;
   logic                            ready;
   logic [fse_pkg::CountWidth-1:0]  go_count;
   logic [fse_pkg::CountWidth-1:0]  wait_count;

   modport source (output valid, output go_count, output wait_count, input ready);
   modport sink (input valid, input go_count, input wait_count, output ready);
endinterface

[rtl/fse_rsp_if.sv]
interface fse_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fse_pkg::ExtWidth-1:0]  extension_tenths;
   logic                          no_rule_fired;

   modport source (output valid, output extension_tenths, output no_rule_fired, input ready);
   modport sink (input valid, input extension_tenths, input no_rule_fired, output ready);
endinterface

[rtl/fuzzy_signal_extension_top.sv]
// throughput: one beat per cycle while the skid register is empty; six
//   pipeline stages plus an output register and a skid register, the divider
//   split over three of the stages
// reset: synchronous, active high; clears all valid bits and loads the default
//   rule table
module fuzzy_signal_extension_top (
   input  logic                                clock,
   input  logic                                reset,
   fse_req_if.sink                             req_if,
   fse_rsp_if.source                           rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fse_pkg::AddrWidth-1:0]       paddr,
   input  logic [fse_pkg::TableWidth-1:0]      pwdata,
   output logic [fse_pkg::TableWidth-1:0]      prdata,
   output logic                                pready
);

`include "fuzzy_signal_extension_top_assert.svh"

   localparam int NumStages = 6;

   function automatic logic [fse_pkg::MuWidth-1:0] member_tenths(
      input logic [fse_pkg::SetIdxWidth-1:0] set_idx,
      input logic [fse_pkg::CountWidth-1:0]  x
   );
      logic [fse_pkg::CountWidth-1:0] c;
      logic [fse_pkg::CountWidth-1:0] d;
      c = fse_pkg::CountWidth'(set_idx) * fse_pkg::CountWidth'(fse_pkg::CentreStep);
      d = (x >= c) ? (x - c) : (c - x);
      if (d == fse_pkg::CountWidth'(0)) begin
         return fse_pkg::MuFull;
      end else if (d == fse_pkg::CountWidth'(1)) begin
         return fse_pkg::MuNear;
      end else if (d == fse_pkg::CountWidth'(2)) begin
         return fse_pkg::MuFar;
      end
      return fse_pkg::MuNone;
   endfunction

   function automatic fse_pkg::div_state_type div_step(
      input fse_pkg::div_state_type         st,
      input logic [fse_pkg::QuoIdxWidth-1:0] pos
   );
      fse_pkg::div_state_type nx;
      logic [fse_pkg::NumWidth+fse_pkg::QuoWidth-1:0] trial;
      nx = st;
      trial = (fse_pkg::NumWidth + fse_pkg::QuoWidth)'(st.div) << pos;
      if (trial <= (fse_pkg::NumWidth + fse_pkg::QuoWidth)'(st.rem)) begin
         nx.rem      = st.rem - trial[fse_pkg::NumWidth-1:0];
         nx.quo[pos] = 1'b1;
      end
      return nx;
   endfunction

   // csr
   logic [fse_pkg::TableWidth-1:0] rule_table_ff;
   logic [fse_pkg::TableWidth-1:0] rule_table_in;

   always_comb begin
      rule_table_in = rule_table_ff;
      if (psel && penable && pwrite && paddr[fse_pkg::AddrWidth-1] == 1'b0) begin
         rule_table_in = pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[fse_pkg::AddrWidth-1] == 1'b0) ? rule_table_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_table_ff <= fse_pkg::RuleTableReset;
      end else begin
         rule_table_ff <= rule_table_in;
      end
   end

   // pipeline control
   logic                 advance;
   logic [NumStages-1:0] stage_valid_ff;
   logic [NumStages-1:0] stage_valid_in;
   logic                 skid_valid_ff;

   assign advance        = !skid_valid_ff;
   assign req_if.ready   = advance && !reset;
   assign stage_valid_in = advance ? {stage_valid_ff[NumStages-2:0], req_if.valid}
                                   : stage_valid_ff;

   // stage 1: fuzzify
   logic [fse_pkg::MuWidth-1:0] mu_go_ff   [fse_pkg::NumSets];
   logic [fse_pkg::MuWidth-1:0] mu_wait_ff [fse_pkg::NumSets];
   logic [fse_pkg::MuWidth-1:0] mu_go_in   [fse_pkg::NumSets];
   logic [fse_pkg::MuWidth-1:0] mu_wait_in [fse_pkg::NumSets];

   always_comb begin
      for (int s = 0; s < fse_pkg::NumSets; s++) begin
         mu_go_in[s]   = member_tenths(fse_pkg::SetIdxWidth'(s), req_if.go_count);
         mu_wait_in[s] = member_tenths(fse_pkg::SetIdxWidth'(s), req_if.wait_count);
      end
   end

   // stage 2: rule strengths, weighted row sums
   logic [fse_pkg::RowSumWidth-1:0] row_sum_ff [fse_pkg::NumSets];
   logic [fse_pkg::RowDenWidth-1:0] row_den_ff [fse_pkg::NumSets];
   logic [fse_pkg::RowSumWidth-1:0] row_sum_in [fse_pkg::NumSets];
   logic [fse_pkg::RowDenWidth-1:0] row_den_in [fse_pkg::NumSets];

   always_comb begin
      logic [fse_pkg::MuWidth-1:0]   strength;
      logic [fse_pkg::ConsWidth-1:0] cons;
      logic [fse_pkg::ProdWidth-1:0] prod;
      for (int g = 0; g < fse_pkg::NumSets; g++) begin
         row_sum_in[g] = '0;
         row_den_in[g] = '0;
         for (int w = 0; w < fse_pkg::NumSets; w++) begin
            strength = (mu_go_ff[g] < mu_wait_ff[w]) ? mu_go_ff[g] : mu_wait_ff[w];
            cons = rule_table_ff[fse_pkg::ConsWidth*(fse_pkg::NumSets*g+w) +:
                                 fse_pkg::ConsWidth];
            prod = fse_pkg::ProdWidth'(strength) * fse_pkg::ProdWidth'(cons);
            row_sum_in[g] = row_sum_in[g] + fse_pkg::RowSumWidth'(prod);
            row_den_in[g] = row_den_in[g] + fse_pkg::RowDenWidth'(strength);
         end
      end
   end

   // stage 3: totals, scaled dividend and divisor
   fse_pkg::div_state_type div0_ff, div0_in;

   always_comb begin
      logic [fse_pkg::SumWidth-1:0] sum_total;
      logic [fse_pkg::DenWidth-1:0] den_total;
      sum_total = '0;
      den_total = '0;
      for (int g = 0; g < fse_pkg::NumSets; g++) begin
         sum_total = sum_total + fse_pkg::SumWidth'(row_sum_ff[g]);
         den_total = den_total + fse_pkg::DenWidth'(row_den_ff[g]);
      end
      // round half up: (2*10*num + den) / (2*den), num = 3*sum
      div0_in.rem  = fse_pkg::NumWidth'(sum_total) * fse_pkg::NumWidth'(fse_pkg::ScaleNum)
                   + fse_pkg::NumWidth'(den_total);
      div0_in.div  = {den_total, 1'b0};
      div0_in.quo  = '0;
      div0_in.none = (den_total == '0);
   end

   // stages 4 to 6: restoring divide, quotient bits high to low
   fse_pkg::div_state_type div1_ff, div1_in;
   fse_pkg::div_state_type div2_ff, div2_in;
   fse_pkg::div_state_type div3_ff, div3_in;

   always_comb begin
      div1_in = div_step(div_step(div_step(div0_ff, 3'd6), 3'd5), 3'd4);
      div2_in = div_step(div_step(div1_ff, 3'd3), 3'd2);
      div3_in = div_step(div_step(div2_ff, 3'd1), 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (advance) begin
         mu_go_ff   <= mu_go_in;
         mu_wait_ff <= mu_wait_in;
         row_sum_ff <= row_sum_in;
         row_den_ff <= row_den_in;
         div0_ff    <= div0_in;
         div1_ff    <= div1_in;
         div2_ff    <= div2_in;
         div3_ff    <= div3_in;
      end
   end

   // output register and skid
   logic [fse_pkg::ExtWidth-1:0] last_ext;
   logic                         last_valid;
   logic                         take_last;

   logic [fse_pkg::ExtWidth-1:0] out_ext_ff, out_ext_in;
   logic                         out_none_ff, out_none_in;
   logic                         out_valid_ff, out_valid_in;
   logic [fse_pkg::ExtWidth-1:0] skid_ext_ff, skid_ext_in;
   logic                         skid_none_ff, skid_none_in;
   logic                         skid_valid_in;

   assign last_ext   = div3_ff.none ? '0 : div3_ff.quo;
   assign last_valid = stage_valid_ff[NumStages-1];
   assign take_last  = last_valid && advance;

   always_comb begin
      out_ext_in    = out_ext_ff;
      out_none_in   = out_none_ff;
      out_valid_in  = out_valid_ff;
      skid_ext_in   = skid_ext_ff;
      skid_none_in  = skid_none_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_if.ready) begin
         if (skid_valid_ff) begin
            out_ext_in    = skid_ext_ff;
            out_none_in   = skid_none_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_ext_in   = last_ext;
            out_none_in  = div3_ff.none;
            out_valid_in = take_last;
         end
      end else if (take_last) begin
         skid_ext_in   = last_ext;
         skid_none_in  = div3_ff.none;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ext_ff   <= out_ext_in;
      out_none_ff  <= out_none_in;
      skid_ext_ff  <= skid_ext_in;
      skid_none_ff <= skid_none_in;
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.extension_tenths = out_ext_ff;
   assign rsp_if.no_rule_fired    = out_none_ff;

   `FSE_ASSERT_IMPLY(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid holds a beat while the output register is empty")
   `FSE_ASSERT_NEXT(a_stall_holds_last, clock, reset, !advance && last_valid,
      last_valid && $stable(div3_ff), "last stage changed while stalled")
   `FSE_ASSERT_IMPLY(a_none_gives_zero, clock, reset, out_valid_ff && out_none_ff,
      out_ext_ff == '0, "extension not zero when no rule fired")
   `FSE_ASSERT_IMPLY(a_ext_in_range, clock, reset, out_valid_ff,
      out_ext_ff <= fse_pkg::ExtWidth'(fse_pkg::ExtMax), "extension above full scale")

endmodule
